// ----- hw/rtl/jsu_pkg.sv -----
// Shared types, codes and UTF-8 / escape helper functions for the JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  typedef enum logic [2:0] {
    KIND_BYTE       = 3'd0,
    KIND_CLOSED     = 3'd1,
    KIND_UNTERM_STR = 3'd2,
    KIND_UNTERM_ESC = 3'd3,
    KIND_TRUNC_HEX  = 3'd4,
    KIND_BAD_HEX    = 3'd5,
    KIND_UNK_ESC    = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    MODE_AWAIT   = 4'd0,
    MODE_BODY    = 4'd1,
    MODE_ESC     = 4'd2,
    MODE_HEX     = 4'd3,
    MODE_HIGH    = 4'd4,
    MODE_HIGH_BS = 4'd5,
    MODE_LOW_HEX = 4'd6
  } mode_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // One decoded word group: up to two code points, one raw byte and one status code,
  // delivered in that order.
  typedef struct packed {
    logic        cp1_valid;
    logic [20:0] cp1;
    logic        cp2_valid;
    logic [15:0] cp2;
    logic        raw_valid;
    logic [7:0]  raw;
    logic        tail_valid;
    kind_t       tail;
  } cmd_t;

  // Hex digit decode: bit 4 is set when the character is a hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    case (c) inside
      [8'h30:8'h39]: r = {1'b1, c[3:0]};
      [8'h61:8'h66],
      [8'h41:8'h46]: r = {1'b1, c[3:0] + 4'd9};
      default:       r = 5'd0;
    endcase
    return r;
  endfunction

  // Simple escape map: bit 8 is set for a known single-byte escape.
  function automatic logic [8:0] esc_map(input logic [7:0] e);
    logic [8:0] r;
    r = 9'd0;
    case (e)
      8'h22:   r = {1'b1, 8'h22};
      8'h5C:   r = {1'b1, 8'h5C};
      8'h2F:   r = {1'b1, 8'h2F};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0C};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h74:   r = {1'b1, 8'h09};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_high_surr(input logic [15:0] v);
    return (v >= 16'hD800) && (v <= 16'hDBFF);
  endfunction

  function automatic logic is_low_surr(input logic [15:0] v);
    return (v >= 16'hDC00) && (v <= 16'hDFFF);
  endfunction

  // Number of UTF-8 bytes minus one.
  function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
    logic [1:0] r;
    if (cp <= 21'h7F) begin
      r = 2'd0;
    end else if (cp <= 21'h7FF) begin
      r = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] len_m1,
                                           input logic [1:0] idx);
    logic [7:0] r;
    r = 8'd0;
    case (len_m1)
      2'd0: r = cp[7:0];
      2'd1: r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      2'd2: begin
        case (idx)
          2'd0:    r = {4'b1110, cp[15:12]};
          2'd1:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    r = {5'b11110, cp[20:18]};
          2'd1:    r = {2'b10, cp[17:12]};
          2'd2:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/jsu_in_if.sv -----
// Input channel interface: one text byte or an end-of-text mark per word.
`timescale 1ns / 1ps
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_end;

  modport source (output valid, output in_byte, output text_end, input ready);
  modport sink   (input valid, input in_byte, input text_end, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/jsu_out_if.sv -----
// Output channel interface: one UTF-8 byte or status code per word.
`timescale 1ns / 1ps
`default_nettype none

interface jsu_out_if import jsu_pkg::*; ;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  kind_t      kind;
  logic       last_in_run;

  modport source (output valid, output out_byte, output kind, output last_in_run, input ready);
  modport sink   (input valid, input out_byte, input kind, input last_in_run, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/jsu_front.sv -----
// Front end: escape and surrogate state machine that turns text bytes into commands; some bytes yield none.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front import jsu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  jsu_in_if.sink    in_ch,
  input  wire logic q_full,
  output logic      push,
  output cmd_t      cmd
);

  mode_t       mode, mode_next;
  logic [15:0] hex_value, hex_value_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] pending_high, pending_high_next;

  logic        fire;
  logic [7:0]  b;
  logic        text_end;
  logic [4:0]  hd;
  logic [8:0]  em;
  logic [15:0] hex_new;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && !q_full;
  assign b           = in_ch.in_byte;
  assign text_end    = in_ch.text_end;
  assign hd          = hex_digit(b);
  assign em          = esc_map(b);
  assign hex_new     = {hex_value[11:0], hd[3:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_AWAIT;
      hex_value    <= 16'd0;
      hex_count    <= 2'd0;
      pending_high <= 16'd0;
    end else if (fire) begin
      mode         <= mode_next;
      hex_value    <= hex_value_next;
      hex_count    <= hex_count_next;
      pending_high <= pending_high_next;
    end
  end

  always_comb begin
    cmd               = '0;
    cmd.tail          = KIND_BYTE;
    mode_next         = mode;
    hex_value_next    = hex_value;
    hex_count_next    = hex_count;
    pending_high_next = pending_high;

    case (mode)
      MODE_BODY: begin
        if (text_end) begin
          cmd.tail_valid = 1'b1;
          cmd.tail       = KIND_UNTERM_STR;
          mode_next      = MODE_AWAIT;
        end else if (b == CH_QUOTE) begin
          cmd.tail_valid = 1'b1;
          cmd.tail       = KIND_CLOSED;
          mode_next      = MODE_AWAIT;
        end else if (b == CH_BSLASH) begin
          mode_next = MODE_ESC;
        end else begin
          cmd.raw_valid = 1'b1;
          cmd.raw       = b;
        end
      end

      MODE_ESC: begin
        if (text_end) begin
          cmd.tail_valid = 1'b1;
          cmd.tail       = KIND_UNTERM_ESC;
          mode_next      = MODE_AWAIT;
        end else if (b == CH_U) begin
          mode_next      = MODE_HEX;
          hex_value_next = 16'd0;
          hex_count_next = 2'd0;
        end else if (em[8]) begin
          cmd.raw_valid = 1'b1;
          cmd.raw       = em[7:0];
          mode_next     = MODE_BODY;
        end else begin
          cmd.tail_valid = 1'b1;
          cmd.tail       = KIND_UNK_ESC;
          mode_next      = MODE_AWAIT;
        end
      end

      MODE_HEX: begin
        if (text_end) begin
          cmd.tail_valid = 1'b1;
          cmd.tail       = KIND_TRUNC_HEX;
          mode_next      = MODE_AWAIT;
        end else if (!hd[4]) begin
          cmd.tail_valid = 1'b1;
          cmd.tail       = KIND_BAD_HEX;
          mode_next      = MODE_AWAIT;
        end else begin
          hex_value_next = hex_new;
          if (hex_count == 2'd3) begin
            hex_count_next = 2'd0;
            if (is_high_surr(hex_new)) begin
              pending_high_next = hex_new;
              mode_next         = MODE_HIGH;
            end else begin
              cmd.cp1_valid = 1'b1;
              cmd.cp1       = {5'd0, hex_new};
              mode_next     = MODE_BODY;
            end
          end else begin
            hex_count_next = hex_count + 2'd1;
          end
        end
      end

      MODE_HIGH: begin
        cmd.cp1_valid = 1'b1;
        cmd.cp1       = {5'd0, pending_high};
        if (text_end) begin
          cmd.tail_valid = 1'b1;
          cmd.tail       = KIND_UNTERM_STR;
          mode_next      = MODE_AWAIT;
        end else if (b == CH_BSLASH) begin
          // Hold the high surrogate back until the next escape shows whether it pairs.
          cmd.cp1_valid = 1'b0;
          mode_next     = MODE_HIGH_BS;
        end else if (b == CH_QUOTE) begin
          cmd.tail_valid = 1'b1;
          cmd.tail       = KIND_CLOSED;
          mode_next      = MODE_AWAIT;
        end else begin
          cmd.raw_valid = 1'b1;
          cmd.raw       = b;
          mode_next     = MODE_BODY;
        end
      end

      MODE_HIGH_BS: begin
        if (!text_end && (b == CH_U)) begin
          mode_next      = MODE_LOW_HEX;
          hex_value_next = 16'd0;
          hex_count_next = 2'd0;
        end else begin
          cmd.cp1_valid = 1'b1;
          cmd.cp1       = {5'd0, pending_high};
          if (text_end) begin
            cmd.tail_valid = 1'b1;
            cmd.tail       = KIND_UNTERM_ESC;
            mode_next      = MODE_AWAIT;
          end else if (em[8]) begin
            cmd.raw_valid = 1'b1;
            cmd.raw       = em[7:0];
            mode_next     = MODE_BODY;
          end else begin
            cmd.tail_valid = 1'b1;
            cmd.tail       = KIND_UNK_ESC;
            mode_next      = MODE_AWAIT;
          end
        end
      end

      MODE_LOW_HEX: begin
        if (text_end) begin
          cmd.tail_valid = 1'b1;
          cmd.tail       = KIND_TRUNC_HEX;
          mode_next      = MODE_AWAIT;
        end else if (!hd[4]) begin
          cmd.tail_valid = 1'b1;
          cmd.tail       = KIND_BAD_HEX;
          mode_next      = MODE_AWAIT;
        end else begin
          hex_value_next = hex_new;
          if (hex_count == 2'd3) begin
            hex_count_next = 2'd0;
            cmd.cp1_valid  = 1'b1;
            if (is_low_surr(hex_new)) begin
              cmd.cp1   = SUPP_BASE + {1'b0, pending_high[9:0], hex_new[9:0]};
              mode_next = MODE_BODY;
            end else begin
              cmd.cp1 = {5'd0, pending_high};
              if (is_high_surr(hex_new)) begin
                pending_high_next = hex_new;
                mode_next         = MODE_HIGH;
              end else begin
                cmd.cp2_valid = 1'b1;
                cmd.cp2       = hex_new;
                mode_next     = MODE_BODY;
              end
            end
          end else begin
            hex_count_next = hex_count + 2'd1;
          end
        end
      end

      default: begin
        // Awaiting a string: the first byte is its opening quote, taken unchecked.
        if (text_end) begin
          cmd.tail_valid = 1'b1;
          cmd.tail       = KIND_UNTERM_STR;
          mode_next      = MODE_AWAIT;
        end else begin
          mode_next = MODE_BODY;
        end
      end
    endcase

    push = fire && (cmd.cp1_valid || cmd.cp2_valid || cmd.raw_valid || cmd.tail_valid);
  end

endmodule

`default_nettype wire

// ----- hw/rtl/jsu_cmd_fifo.sv -----
// Command queue between the front end and the byte sequencer.
`timescale 1ns / 1ps
`default_nettype none

module jsu_cmd_fifo import jsu_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             store [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/jsu_back.sv -----
// Back end: expands one command at a time into UTF-8 bytes and status words.
`timescale 1ns / 1ps
`default_nettype none

module jsu_back import jsu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  cmd_t      q_data,
  input  wire logic q_avail,
  output logic      q_pop,
  jsu_out_if.source out_ch
);

  cmd_t       cur, cur_next;
  logic [1:0] sub, sub_next;

  logic       o_valid;
  logic [7:0] o_byte;
  kind_t      o_kind;
  logic       o_last;

  logic       cur_any;
  logic       adv;
  logic [1:0] len1, len2;
  logic [7:0] e_byte;
  kind_t      e_kind;
  logic       e_done;
  logic       e_last;

  assign cur_any = cur.cp1_valid || cur.cp2_valid || cur.raw_valid || cur.tail_valid;
  assign adv     = cur_any && (!o_valid || out_ch.ready);
  assign len1    = utf8_len_m1(cur.cp1);
  assign len2    = utf8_len_m1({5'd0, cur.cp2});

  // Pick the element at the head of the current command.
  always_comb begin
    e_byte = 8'd0;
    e_kind = KIND_BYTE;
    e_done = 1'b1;
    e_last = 1'b1;
    if (cur.cp1_valid) begin
      e_byte = utf8_byte(cur.cp1, len1, sub);
      e_done = (sub == len1);
      e_last = e_done && !(cur.cp2_valid || cur.raw_valid || cur.tail_valid);
    end else if (cur.cp2_valid) begin
      e_byte = utf8_byte({5'd0, cur.cp2}, len2, sub);
      e_done = (sub == len2);
      e_last = e_done && !(cur.raw_valid || cur.tail_valid);
    end else if (cur.raw_valid) begin
      e_byte = cur.raw;
      e_last = !cur.tail_valid;
    end else begin
      e_kind = cur.tail;
    end
  end

  always_comb begin
    cur_next = cur;
    sub_next = sub;
    q_pop    = 1'b0;
    if (!cur_any || (adv && e_last)) begin
      q_pop    = q_avail;
      cur_next = q_avail ? q_data : '0;
      sub_next = 2'd0;
    end else if (adv) begin
      if (!e_done) begin
        sub_next = sub + 2'd1;
      end else begin
        sub_next = 2'd0;
        if (cur.cp1_valid) begin
          cur_next.cp1_valid = 1'b0;
        end else if (cur.cp2_valid) begin
          cur_next.cp2_valid = 1'b0;
        end else begin
          cur_next.raw_valid = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur     <= '0;
      sub     <= 2'd0;
      o_valid <= 1'b0;
    end else begin
      cur <= cur_next;
      sub <= sub_next;
      if (adv) begin
        o_valid <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_byte <= e_byte;
      o_kind <= e_kind;
      o_last <= e_last;
    end
  end

  assign out_ch.valid       = o_valid;
  assign out_ch.out_byte    = o_byte;
  assign out_ch.kind        = o_kind;
  assign out_ch.last_in_run = o_last;

endmodule

`default_nettype wire

// ----- hw/rtl/json_string_unescape_utf8_core.sv -----
// Top level of the JSON string unescaper: front end, command queue and byte sequencer.
//
// The block reads the text of JSON strings one word at a time on in_ch: a byte, or an
// end-of-text mark (text_end set). The first byte of a string is its opening quote and
// is dropped unchecked. Plain bytes pass unchanged, simple escapes become one byte, and
// \u escapes become 1 to 4 UTF-8 bytes, with high/low surrogate pairs joined. Results
// leave on out_ch as words carrying a byte (kind 0) or a status code: closed string or
// one of the error kinds. last_in_run marks the final word caused by one input word.
// Input words that give no result (opening quote, backslash, hex digits) give none.
//
// The front end takes one input word per cycle as long as the command queue has room;
// each word turns into at most one queue entry. The back end sends one output word
// per cycle while out_ch.ready is high, so a word that yields N results takes N
// output words (N is at most six). Sustained input rate is one word per cycle
// while out_ch.ready stays high and results average one per input word or less.
// Each command passes the queue and cur before its words reach the output register.
//
// When the receiver holds out_ch.ready low, the output register holds its word, the
// sequencer stops, and the queue fills; in_ch.ready drops once QUEUE_DEPTH commands
// are waiting. Synchronous reset empties the queue and output, and returns the decoder
// to waiting for the opening quote of a new string.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8_core import jsu_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic q_full;
  logic q_pop;
  logic q_avail;

  // Decoder state machine; each accepted word yields at most one command.
  jsu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  // Decouples the decoder from output back-pressure.
  jsu_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (head_cmd),
    .not_empty (q_avail)
  );

  // Expands each command into output words, one word per cycle while out_ch.ready allows.
  jsu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (head_cmd),
    .q_avail (q_avail),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
